FILE: src/csv_pkg.sv
package csv_pkg;

  localparam int FIELD_COUNT = 9;
  localparam int CNT_W = $clog2(FIELD_COUNT + 1);
  localparam int IDX_W = $clog2(FIELD_COUNT);

  localparam logic [3:0] ST_OK       = 4'd0;
  localparam logic [3:0] ST_EMPTY    = 4'd1;
  localparam logic [3:0] ST_TOO_MANY = 4'd2;
  localparam logic [3:0] ST_NOT_INT  = 4'd3;
  localparam logic [3:0] ST_COUNT    = 4'd4;
  localparam logic [3:0] ST_FACTOR   = 4'd5;
  localparam logic [3:0] ST_MOVE     = 4'd6;
  localparam logic [3:0] ST_HOLD     = 4'd7;
  localparam logic [3:0] ST_SPEED    = 4'd8;
  localparam logic [3:0] ST_ACCEL    = 4'd9;

  localparam logic [2:0] REG_MOVE_MIN  = 3'd0;
  localparam logic [2:0] REG_MOVE_MAX  = 3'd1;
  localparam logic [2:0] REG_HOLD_MAX  = 3'd2;
  localparam logic [2:0] REG_SPEED_MIN = 3'd3;
  localparam logic [2:0] REG_SPEED_MAX = 3'd4;
  localparam logic [2:0] REG_ACCEL_MAX = 3'd5;

  localparam logic KIND_CHAR = 1'b0;
  localparam logic KIND_END  = 1'b1;

  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;

  localparam logic [7:0] FACTOR_MAX = 8'd100;

  localparam logic [31:0] SAT_POS = 32'h7FFF_FFFF;
  localparam logic [31:0] SAT_NEG = 32'h8000_0000;

endpackage

FILE: src/csv_step_record_parser.sv
// A result word is registered and appears on the master side in the cycle after its end word is taken.
// Throughput: one input word per cycle while no result waits; character words give no result.
// The output register frees as it is taken, so input stalls only while a result waits.
// Reset (rst, synchronous, active high) clears the parse state and the output valid,
// and loads the limit registers with their default values.
module csv_step_record_parser
  import csv_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [7:0]   s_tdata,   // char_code[7:0]
  input  logic         s_tuser,   // kind
  output logic         m_tvalid,
  input  logic         m_tready,
  // status[3:0], factor_a[11:4], factor_b[19:12], factor_c[27:20], factor_d[35:28],
  // factor_e[43:36], move_ms[59:44], hold_ms[75:60], speed_value[91:76],
  // accel_value[99:92], zero[103:100]
  output logic [103:0] m_tdata,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [4:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  typedef enum logic [2:0] {
    PH_LEAD,
    PH_SIGN,
    PH_DIGIT,
    PH_TRAIL,
    PH_BAD
  } phase_t;

  logic [15:0] move_min, move_max, hold_max, speed_min, speed_max;
  logic [7:0]  accel_max;

  phase_t             phase, phase_next;
  logic [CNT_W-1:0]   field_cnt, field_cnt_next;
  logic [31:0]        acc, acc_next;
  logic               neg, neg_next;
  logic [3:0]         first_err, first_err_next;
  logic [15:0]        field_store [FIELD_COUNT];

  logic               accept, is_end;
  logic [7:0]         ch;
  logic               is_digit, is_blank;
  logic [3:0]         digit_val;
  logic [35:0]        acc_mul;
  logic [31:0]        sat_lim;
  logic [15:0]        close_val;
  logic [3:0]         close_err;
  logic               close_store;
  logic               store_we;
  logic [15:0]        eff [FIELD_COUNT];
  logic [3:0]         status;
  logic               factor_bad;
  logic [2:0]         cfg_idx;
  logic               cfg_wr;

  assign pready   = 1'b1;
  assign cfg_idx  = paddr[4:2];
  assign cfg_wr   = psel & penable & pwrite & pready;
  assign s_tready = ~m_tvalid | m_tready;
  assign accept   = s_tvalid & s_tready;
  assign is_end   = (s_tuser == KIND_END);
  assign ch       = s_tdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      move_min  <= 16'd50;
      move_max  <= 16'd10000;
      hold_max  <= 16'd60000;
      speed_min <= 16'd1;
      speed_max <= 16'd1000;
      accel_max <= 8'd255;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_MOVE_MIN:  move_min  <= pwdata[15:0];
        REG_MOVE_MAX:  move_max  <= pwdata[15:0];
        REG_HOLD_MAX:  hold_max  <= pwdata[15:0];
        REG_SPEED_MIN: speed_min <= pwdata[15:0];
        REG_SPEED_MAX: speed_max <= pwdata[15:0];
        REG_ACCEL_MAX: accel_max <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_MOVE_MIN:  prdata = {16'd0, move_min};
      REG_MOVE_MAX:  prdata = {16'd0, move_max};
      REG_HOLD_MAX:  prdata = {16'd0, hold_max};
      REG_SPEED_MIN: prdata = {16'd0, speed_min};
      REG_SPEED_MAX: prdata = {16'd0, speed_max};
      REG_ACCEL_MAX: prdata = {24'd0, accel_max};
      default:       prdata = 32'd0;
    endcase
  end

  assign is_digit  = (ch >= CH_ZERO) && (ch <= CH_NINE);
  assign is_blank  = (ch == CH_SPACE) || ((ch >= CH_TAB) && (ch <= CH_CR));
  assign digit_val = 4'(ch - CH_ZERO);
  assign acc_mul   = ({4'd0, acc} << 3) + ({4'd0, acc} << 1) + {32'd0, digit_val};
  assign sat_lim   = neg ? SAT_NEG : SAT_POS;
  assign close_val = neg ? 16'(16'd0 - acc[15:0]) : acc[15:0];

  // close the current field
  always_comb begin
    close_err   = first_err;
    close_store = 1'b0;
    if (first_err == ST_OK) begin
      if (phase == PH_LEAD) begin
        close_err = ST_EMPTY;
      end else if (field_cnt >= CNT_W'(FIELD_COUNT)) begin
        close_err = ST_TOO_MANY;
      end else if (phase != PH_DIGIT && phase != PH_TRAIL) begin
        close_err = ST_NOT_INT;
      end else begin
        close_store = 1'b1;
      end
    end
  end

  always_comb begin
    phase_next     = phase;
    field_cnt_next = field_cnt;
    acc_next       = acc;
    neg_next       = neg;
    first_err_next = first_err;
    store_we       = 1'b0;
    if (accept) begin
      if (is_end) begin
        phase_next     = PH_LEAD;
        field_cnt_next = '0;
        acc_next       = '0;
        neg_next       = 1'b0;
        first_err_next = ST_OK;
        store_we       = close_store;
      end else if (first_err == ST_OK) begin
        if (ch == CH_COMMA) begin
          first_err_next = close_err;
          store_we       = close_store;
          if (close_store) begin
            field_cnt_next = field_cnt + 1'b1;
          end
          phase_next = PH_LEAD;
          acc_next   = '0;
          neg_next   = 1'b0;
        end else begin
          case (phase)
            PH_LEAD: begin
              if (is_blank) begin
                phase_next = PH_LEAD;
              end else if (ch == CH_MINUS || ch == CH_PLUS) begin
                neg_next   = (ch == CH_MINUS);
                phase_next = PH_SIGN;
              end else if (is_digit) begin
                acc_next   = {28'd0, digit_val};
                phase_next = PH_DIGIT;
              end else begin
                phase_next = PH_BAD;
              end
            end
            PH_SIGN: begin
              if (is_digit) begin
                acc_next   = {28'd0, digit_val};
                phase_next = PH_DIGIT;
              end else begin
                phase_next = PH_BAD;
              end
            end
            PH_DIGIT: begin
              if (is_digit) begin
                acc_next = (acc_mul > {4'd0, sat_lim}) ? sat_lim : acc_mul[31:0];
              end else if (is_blank) begin
                phase_next = PH_TRAIL;
              end else begin
                phase_next = PH_BAD;
              end
            end
            PH_TRAIL: begin
              if (!is_blank) begin
                phase_next = PH_BAD;
              end
            end
            default: phase_next = PH_BAD;
          endcase
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_LEAD;
      field_cnt <= '0;
      acc       <= '0;
      neg       <= 1'b0;
      first_err <= ST_OK;
    end else begin
      phase     <= phase_next;
      field_cnt <= field_cnt_next;
      acc       <= acc_next;
      neg       <= neg_next;
      first_err <= first_err_next;
    end
  end

  always_ff @(posedge clk) begin
    if (store_we) begin
      field_store[field_cnt[IDX_W-1:0]] <= close_val;
    end
  end

  // bypass the field closed by the end word
  always_comb begin
    for (int i = 0; i < FIELD_COUNT; i++) begin
      eff[i] = (close_store && field_cnt == CNT_W'(i)) ? close_val : field_store[i];
    end
  end

  always_comb begin
    factor_bad = 1'b0;
    for (int i = 0; i < 5; i++) begin
      if (eff[i][7:0] > FACTOR_MAX) begin
        factor_bad = 1'b1;
      end
    end
  end

  always_comb begin
    if (close_err != ST_OK) begin
      status = close_err;
    end else if (field_cnt != CNT_W'(FIELD_COUNT - 1)) begin
      status = ST_COUNT;
    end else if (factor_bad) begin
      status = ST_FACTOR;
    end else if (eff[5] < move_min || eff[5] > move_max) begin
      status = ST_MOVE;
    end else if (eff[6] > hold_max) begin
      status = ST_HOLD;
    end else if (eff[7] < speed_min || eff[7] > speed_max) begin
      status = ST_SPEED;
    end else if (eff[8][7:0] > accel_max) begin
      status = ST_ACCEL;
    end else begin
      status = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (accept && is_end) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && is_end) begin
      m_tdata[3:0]     <= status;
      m_tdata[103:100] <= 4'd0;
      if (status >= ST_EMPTY && status <= ST_COUNT) begin
        m_tdata[99:4] <= '0;
      end else begin
        m_tdata[11:4]  <= eff[0][7:0];
        m_tdata[19:12] <= eff[1][7:0];
        m_tdata[27:20] <= eff[2][7:0];
        m_tdata[35:28] <= eff[3][7:0];
        m_tdata[43:36] <= eff[4][7:0];
        m_tdata[59:44] <= eff[5];
        m_tdata[75:60] <= eff[6];
        m_tdata[91:76] <= eff[7];
        m_tdata[99:92] <= eff[8][7:0];
      end
    end
  end

endmodule
